// ----- hdl/mmenc_pkg.sv -----
`timescale 1ns / 1ps

package mmenc_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CNT_W        = 32;
    localparam int NUM_STATS    = 5;

    // command codes carried in tuser
    localparam logic [3:0] MODE_CC      = 4'd0;
    localparam logic [3:0] MODE_PROGRAM = 4'd1;
    localparam logic [3:0] MODE_NOTE_ON = 4'd2;
    localparam logic [3:0] MODE_TRACKED = 4'd3;
    localparam logic [3:0] MODE_NOTE_OFF = 4'd4;
    localparam logic [3:0] MODE_ALL_OFF = 4'd5;
    localparam logic [3:0] MODE_SILENCE = 4'd6;
    localparam logic [3:0] MODE_CLEAR   = 4'd7;
    localparam logic [3:0] MODE_REPORT  = 4'd8;

    // midi message type nibbles
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CC       = 4'hB;
    localparam logic [3:0] MSG_PROGRAM  = 4'hC;

    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

    typedef logic [CNT_W-1:0] counter_t;
    typedef counter_t [NUM_STATS-1:0] counter_bank_t;

    typedef enum logic [2:0] {
        STAT_BYTES = 3'd0,
        STAT_MSGS  = 3'd1,
        STAT_NOTE_ON = 3'd2,
        STAT_NOTE_OFF = 3'd3,
        STAT_CTRL  = 3'd4
    } stat_sel_t;

    typedef struct packed {
        logic      upd;
        logic      clr;
        stat_sel_t sel;
        logic [1:0] amt;
    } stat_op_t;

endpackage

// ----- hdl/mmenc_ram.sv -----
`timescale 1ns / 1ps

module mmenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/mmenc_stats.sv -----
`timescale 1ns / 1ps

// counter bank sharing one 32-bit adder, one counter per update
module mmenc_stats (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mmenc_pkg::stat_op_t    op,
    output mmenc_pkg::counter_bank_t counts
);

    mmenc_pkg::counter_bank_t bank_reg;
    mmenc_pkg::counter_bank_t bank_next;
    mmenc_pkg::counter_t      operand;
    mmenc_pkg::counter_t      sum;

    always_comb
    begin
        unique case (op.sel)
            mmenc_pkg::STAT_BYTES:    operand = bank_reg[0];
            mmenc_pkg::STAT_MSGS:     operand = bank_reg[1];
            mmenc_pkg::STAT_NOTE_ON:  operand = bank_reg[2];
            mmenc_pkg::STAT_NOTE_OFF: operand = bank_reg[3];
            mmenc_pkg::STAT_CTRL:     operand = bank_reg[4];
            default:                  operand = '0;
        endcase
    end

    // wraps at 32 bits
    assign sum = operand + mmenc_pkg::counter_t'(op.amt);

    always_comb
    begin
        bank_next = bank_reg;
        if (op.clr)
        begin
            bank_next = '0;
        end
        else if (op.upd)
        begin
            unique case (op.sel)
                mmenc_pkg::STAT_BYTES:    bank_next[0] = sum;
                mmenc_pkg::STAT_MSGS:     bank_next[1] = sum;
                mmenc_pkg::STAT_NOTE_ON:  bank_next[2] = sum;
                mmenc_pkg::STAT_NOTE_OFF: bank_next[3] = sum;
                mmenc_pkg::STAT_CTRL:     bank_next[4] = sum;
                default:                  bank_next = bank_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '0;
        end
        else
        begin
            bank_reg <= bank_next;
        end
    end

    assign counts = bank_reg;

endmodule

// ----- hdl/midi_message_encoder_with_note_tracker.sv -----
`timescale 1ns / 1ps

// sequencing: a single-message command steps the five counters one per cycle through one
//   shared adder and then raises m_axis_tvalid; clear or report go straight to the output
//   beat; silence reads each held note in turn (ram read, read data, output beat); an empty
//   silence or an ignored mode returns to idle; no new command is taken until the last beat
//   is accepted, and any output stall holds it
// reset: rst_n clears the sequencer, counters and per-channel note counts at once

module midi_message_encoder_with_note_tracker #(
    parameter int NOTES_PER_CHANNEL = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // channel[7:0], data_first[15:8], data_second[23:16]
    input  logic [3:0]   s_axis_tuser,   // mode[3:0]
    // output beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status_byte[7:0], byte_one[14:8], byte_two[21:15], byte_count[23:22],
    // bytes_sent[55:24], messages_sent[87:56], note_ons_sent[119:88],
    // note_offs_sent[151:120], controls_sent[183:152]
    output logic [183:0] m_axis_tdata,
    output logic         m_axis_tlast    // last beat caused by this command
);

    localparam int DEPTH = mmenc_pkg::NUM_CHANNELS * NOTES_PER_CHANNEL;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(NOTES_PER_CHANNEL + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CNT  = 5'b00010,
        S_RD   = 5'b00100,
        S_RDW  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [3:0]             mode_reg, mode_next;
    logic [3:0]             ch_reg, ch_next;
    logic [CW-1:0]          idx_reg, idx_next;
    mmenc_pkg::stat_sel_t   sel_reg, sel_next;
    logic [7:0]             status_reg, status_next;
    logic [6:0]             b1_reg, b1_next;
    logic [6:0]             b2_reg, b2_next;
    logic [1:0]             bcount_reg, bcount_next;
    logic                   last_reg, last_next;
    logic [CW-1:0]          held_count_reg  [mmenc_pkg::NUM_CHANNELS];
    logic [CW-1:0]          held_count_next [mmenc_pkg::NUM_CHANNELS];

    logic                   s_hs, m_hs;
    logic [3:0]             in_mode, in_ch;
    logic [6:0]             in_d1, in_d2;
    logic [CW-1:0]          hc_in, hc_cur;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [6:0]             ram_rdata;

    mmenc_pkg::stat_op_t      stat_op;
    mmenc_pkg::counter_bank_t counts;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign s_hs = s_axis_tvalid && s_axis_tready;
    assign m_hs = m_axis_tvalid && m_axis_tready;

    // field extraction, channel to 4 bits and data to 7 bits
    assign in_mode = s_axis_tuser;
    assign in_ch   = s_axis_tdata[3:0];
    assign in_d1   = s_axis_tdata[14:8];
    assign in_d2   = s_axis_tdata[22:16];
    assign hc_in   = held_count_reg[in_ch];
    assign hc_cur  = held_count_reg[ch_reg];

    // note store: channel-major rows of NOTES_PER_CHANNEL entries
    assign ram_we    = s_hs && (in_mode == mmenc_pkg::MODE_TRACKED)
                       && (hc_in < CW'(NOTES_PER_CHANNEL));
    assign ram_waddr = AW'(in_ch) * AW'(NOTES_PER_CHANNEL) + AW'(hc_in);
    assign ram_re    = (state_reg == S_RD);
    assign ram_raddr = AW'(ch_reg) * AW'(NOTES_PER_CHANNEL) + AW'(idx_reg);

    mmenc_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_notes (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (in_d1),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mmenc_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (stat_op),
        .counts (counts)
    );

    // counter step for the current counter of the sweep
    always_comb
    begin
        stat_op.upd = (state_reg == S_CNT);
        stat_op.clr = s_hs && (in_mode == mmenc_pkg::MODE_CLEAR);
        stat_op.sel = sel_reg;
        stat_op.amt = 2'd0;
        unique case (sel_reg)
            mmenc_pkg::STAT_BYTES:
                stat_op.amt = (mode_reg == mmenc_pkg::MODE_PROGRAM) ? 2'd2 : 2'd3;
            mmenc_pkg::STAT_MSGS:
                stat_op.amt = 2'd1;
            mmenc_pkg::STAT_NOTE_ON:
                stat_op.amt = {1'b0, (mode_reg == mmenc_pkg::MODE_NOTE_ON)
                                     || (mode_reg == mmenc_pkg::MODE_TRACKED)};
            mmenc_pkg::STAT_NOTE_OFF:
                stat_op.amt = {1'b0, mode_reg == mmenc_pkg::MODE_NOTE_OFF};
            mmenc_pkg::STAT_CTRL:
                stat_op.amt = {1'b0, (mode_reg == mmenc_pkg::MODE_CC)
                                     || (mode_reg == mmenc_pkg::MODE_ALL_OFF)};
            default:
                stat_op.amt = 2'd0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        ch_next     = ch_reg;
        idx_next    = idx_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        bcount_next = bcount_reg;
        last_next   = last_reg;
        held_count_next = held_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_hs)
                begin
                    mode_next   = in_mode;
                    ch_next     = in_ch;
                    idx_next    = '0;
                    sel_next    = mmenc_pkg::STAT_BYTES;
                    last_next   = 1'b1;
                    status_next = 8'h00;
                    b1_next     = 7'd0;
                    b2_next     = 7'd0;
                    bcount_next = 2'd0;
                    unique case (in_mode) inside
                        mmenc_pkg::MODE_CC:
                        begin
                            status_next = {mmenc_pkg::MSG_CC, in_ch};
                            b1_next     = in_d1;
                            b2_next     = in_d2;
                            bcount_next = 2'd3;
                            state_next  = S_CNT;
                        end
                        mmenc_pkg::MODE_ALL_OFF:
                        begin
                            status_next = {mmenc_pkg::MSG_CC, in_ch};
                            b1_next     = mmenc_pkg::CC_ALL_NOTES_OFF;
                            bcount_next = 2'd3;
                            state_next  = S_CNT;
                        end
                        mmenc_pkg::MODE_PROGRAM:
                        begin
                            status_next = {mmenc_pkg::MSG_PROGRAM, in_ch};
                            b1_next     = in_d1;
                            bcount_next = 2'd2;
                            state_next  = S_CNT;
                        end
                        mmenc_pkg::MODE_NOTE_ON, mmenc_pkg::MODE_TRACKED:
                        begin
                            status_next = {mmenc_pkg::MSG_NOTE_ON, in_ch};
                            b1_next     = in_d1;
                            b2_next     = in_d2;
                            bcount_next = 2'd3;
                            state_next  = S_CNT;
                            if (ram_we)
                            begin
                                held_count_next[in_ch] = hc_in + CW'(1);
                            end
                        end
                        mmenc_pkg::MODE_NOTE_OFF:
                        begin
                            status_next = {mmenc_pkg::MSG_NOTE_OFF, in_ch};
                            b1_next     = in_d1;
                            bcount_next = 2'd3;
                            state_next  = S_CNT;
                        end
                        mmenc_pkg::MODE_SILENCE:
                        begin
                            // an empty channel gives no beat
                            if (hc_in != '0)
                            begin
                                state_next = S_RD;
                            end
                        end
                        mmenc_pkg::MODE_CLEAR, mmenc_pkg::MODE_REPORT:
                        begin
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                if (sel_reg == mmenc_pkg::STAT_CTRL)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    sel_next = mmenc_pkg::stat_sel_t'(sel_reg + 3'd1);
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                // release of a held note: note on with velocity zero, not counted
                status_next = {mmenc_pkg::MSG_NOTE_ON, ch_reg};
                b1_next     = ram_rdata;
                b2_next     = 7'd0;
                bcount_next = 2'd3;
                last_next   = (idx_reg + CW'(1)) == hc_cur;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (m_hs)
                begin
                    if ((mode_reg == mmenc_pkg::MODE_SILENCE) && !last_reg)
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        if (mode_reg == mmenc_pkg::MODE_SILENCE)
                        begin
                            held_count_next[ch_reg] = '0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < mmenc_pkg::NUM_CHANNELS; i++)
            begin
                held_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
        end
    end

    // payload and command registers, no reset needed
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        ch_reg     <= ch_next;
        idx_reg    <= idx_next;
        sel_reg    <= sel_next;
        status_reg <= status_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        bcount_reg <= bcount_next;
        last_reg   <= last_next;
    end

    assign m_axis_tdata = {counts[4], counts[3], counts[2], counts[1], counts[0],
                           bcount_reg, b2_reg, b1_reg, status_reg};
    assign m_axis_tlast = last_reg;

    // one command in flight: no new beat taken while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    // counter-only beats carry no message bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[23:22] == 2'd0)) |-> (m_axis_tdata[21:0] == '0))
        else $error("counter-only beat with message bytes");

    // a busy channel never tracks more notes than its row holds
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (held_count_reg[ch_reg] <= CW'(NOTES_PER_CHANNEL)))
        else $error("held note count beyond row size");

    // counters stay put while a beat waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata[183:24]))
        else $error("counters moved under a stalled beat");

endmodule

// ----- dv/midi_message_encoder_with_note_tracker_tb.sv -----
`timescale 1ns / 1ps

module midi_message_encoder_with_note_tracker_tb;

    localparam int TRACK_DEPTH = 6;
    localparam int RANDOM_CMDS = 270;

    // modes above report are ignored by the block
    localparam logic [3:0] MODE_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] MODE_LAST_UNUSED  = 4'd15;

    // one output beat as the block should present it
    typedef struct {
        logic [7:0]  status;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [1:0]  nbytes;
        logic        is_last;
        logic [31:0] byte_tally;
        logic [31:0] msg_tally;
        logic [31:0] on_tally;
        logic [31:0] off_tally;
        logic [31:0] ctrl_tally;
    } midi_beat_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [183:0] m_axis_tdata;
    logic         m_axis_tlast;

    // shadow of the note tracker and the statistics counters
    logic [6:0]   note_slots [mmenc_pkg::NUM_CHANNELS][TRACK_DEPTH];
    int           note_fill  [mmenc_pkg::NUM_CHANNELS];
    logic [31:0]  byte_tally, msg_tally, on_tally, off_tally, ctrl_tally;

    midi_beat_t   pending_beats[$];

    bit           calm;          // no idling on either side while set
    int           mismatches;
    int           commands_sent;
    int           beats_checked;
    int           releases_seen;

    midi_message_encoder_with_note_tracker #(
        .NOTES_PER_CHANNEL (TRACK_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // queue one expected beat carrying the current counter values
    task automatic push_beat(input logic [7:0] status, input logic [6:0] d1,
                             input logic [6:0] d2, input logic [1:0] nbytes);
        midi_beat_t b;
        b.status     = status;
        b.data_one   = d1;
        b.data_two   = d2;
        b.nbytes     = nbytes;
        b.is_last    = 1'b0;
        b.byte_tally = byte_tally;
        b.msg_tally  = msg_tally;
        b.on_tally   = on_tally;
        b.off_tally  = off_tally;
        b.ctrl_tally = ctrl_tally;
        pending_beats.push_back(b);
    endtask

    // work out the beats that one accepted command causes
    task automatic encode_command(input logic [3:0] mode, input logic [7:0] chan_raw,
                                  input logic [7:0] d1_raw, input logic [7:0] d2_raw);
        logic [3:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        int         start_size;
        ch = chan_raw[3:0];
        d1 = d1_raw[6:0];
        d2 = d2_raw[6:0];
        start_size = pending_beats.size();
        case (mode) inside
            mmenc_pkg::MODE_CC, mmenc_pkg::MODE_ALL_OFF:
            begin
                if (mode == mmenc_pkg::MODE_ALL_OFF)
                begin
                    d1 = mmenc_pkg::CC_ALL_NOTES_OFF;
                    d2 = 7'd0;
                end
                msg_tally  += 1;
                byte_tally += 3;
                ctrl_tally += 1;
                push_beat({mmenc_pkg::MSG_CC, ch}, d1, d2, 2'd3);
            end
            mmenc_pkg::MODE_PROGRAM:
            begin
                msg_tally  += 1;
                byte_tally += 2;
                push_beat({mmenc_pkg::MSG_PROGRAM, ch}, d1, 7'd0, 2'd2);
            end
            mmenc_pkg::MODE_NOTE_ON, mmenc_pkg::MODE_TRACKED:
            begin
                msg_tally  += 1;
                byte_tally += 3;
                on_tally   += 1;
                push_beat({mmenc_pkg::MSG_NOTE_ON, ch}, d1, d2, 2'd3);
                // a full channel still sends the note but drops it from tracking
                if (mode == mmenc_pkg::MODE_TRACKED && note_fill[ch] < TRACK_DEPTH)
                begin
                    note_slots[ch][note_fill[ch]] = d1;
                    note_fill[ch]++;
                end
            end
            mmenc_pkg::MODE_NOTE_OFF:
            begin
                msg_tally  += 1;
                byte_tally += 3;
                off_tally  += 1;
                push_beat({mmenc_pkg::MSG_NOTE_OFF, ch}, d1, 7'd0, 2'd3);
            end
            mmenc_pkg::MODE_SILENCE:
            begin
                // releases go out in storage order and are not counted
                for (int i = 0; i < note_fill[ch]; i++)
                    push_beat({mmenc_pkg::MSG_NOTE_ON, ch}, note_slots[ch][i], 7'd0, 2'd3);
                releases_seen += note_fill[ch];
                note_fill[ch] = 0;
            end
            mmenc_pkg::MODE_CLEAR:
            begin
                byte_tally = '0;
                msg_tally  = '0;
                on_tally   = '0;
                off_tally  = '0;
                ctrl_tally = '0;
                push_beat(8'd0, 7'd0, 7'd0, 2'd0);
            end
            mmenc_pkg::MODE_REPORT:
            begin
                push_beat(8'd0, 7'd0, 7'd0, 2'd0);
            end
            default:
            begin
            end
        endcase
        if (pending_beats.size() > start_size)
            pending_beats[pending_beats.size() - 1].is_last = 1'b1;
    endtask

    // present one command beat, with a random gap first unless calm
    task automatic send_command(input logic [3:0] mode, input logic [7:0] chan_raw,
                                input logic [7:0] d1_raw, input logic [7:0] d2_raw);
        while (!calm && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {d2_raw, d1_raw, chan_raw};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encode_command(mode, chan_raw, d1_raw, d2_raw);
        commands_sent++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        mismatches++;
    endtask

    // compare one accepted output beat with the oldest expectation
    task automatic check_beat(input logic [183:0] data, input logic tlast);
        midi_beat_t w;
        if (pending_beats.size() == 0)
        begin
            report_mismatch("unexpected beat status", 32'(data[7:0]), 32'd0);
        end
        else
        begin
            w = pending_beats.pop_front();
            if (data[7:0] !== w.status)
                report_mismatch("status_byte", 32'(data[7:0]), 32'(w.status));
            if (data[14:8] !== w.data_one)
                report_mismatch("byte_one", 32'(data[14:8]), 32'(w.data_one));
            if (data[21:15] !== w.data_two)
                report_mismatch("byte_two", 32'(data[21:15]), 32'(w.data_two));
            if (data[23:22] !== w.nbytes)
                report_mismatch("byte_count", 32'(data[23:22]), 32'(w.nbytes));
            if (tlast !== w.is_last)
                report_mismatch("tlast", 32'(tlast), 32'(w.is_last));
            if (data[55:24] !== w.byte_tally)
                report_mismatch("bytes_sent", data[55:24], w.byte_tally);
            if (data[87:56] !== w.msg_tally)
                report_mismatch("messages_sent", data[87:56], w.msg_tally);
            if (data[119:88] !== w.on_tally)
                report_mismatch("note_ons_sent", data[119:88], w.on_tally);
            if (data[151:120] !== w.off_tally)
                report_mismatch("note_offs_sent", data[151:120], w.off_tally);
            if (data[183:152] !== w.ctrl_tally)
                report_mismatch("controls_sent", data[183:152], w.ctrl_tally);
        end
        beats_checked++;
    endtask

    // sink side: random stalls and the beat checker
    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 16);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_beat(m_axis_tdata, m_axis_tlast);
    end

    // message, clear and report commands with field extremes, plus ignored modes
    task automatic test_message_types();
        send_command(mmenc_pkg::MODE_CC, 8'h00, 8'h00, 8'h00);
        send_command(mmenc_pkg::MODE_CC, 8'hFF, 8'hFF, 8'hFF);
        send_command(mmenc_pkg::MODE_PROGRAM, 8'hA5, 8'h80, 8'h7F);
        send_command(mmenc_pkg::MODE_NOTE_ON, 8'h5A, 8'h7F, 8'h80);
        send_command(mmenc_pkg::MODE_NOTE_OFF, 8'h0F, 8'h3C, 8'h64);
        send_command(mmenc_pkg::MODE_ALL_OFF, 8'h71, 8'hAA, 8'h55);
        send_command(mmenc_pkg::MODE_REPORT, 8'h33, 8'hCC, 8'h33);
        send_command(MODE_FIRST_UNUSED, 8'h01, 8'h40, 8'h40);
        send_command(MODE_LAST_UNUSED, 8'hFE, 8'hFF, 8'hFF);
        send_command(mmenc_pkg::MODE_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_command(mmenc_pkg::MODE_REPORT, 8'h00, 8'h00, 8'h00);
    endtask

    // fill a channel past its capacity, release it, release an empty channel
    task automatic test_note_tracking();
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h80, 8'h01);
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h7F, 8'h7F);
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h3C, 8'hFF);
        send_command(mmenc_pkg::MODE_TRACKED, 8'hE2, 8'hC0, 8'h40);
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h01, 8'h20);
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h55, 8'h10);
        // seventh note on a full channel: sent, not tracked
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h66, 8'h66);
        // plain note on never enters the tracker
        send_command(mmenc_pkg::MODE_NOTE_ON, 8'h02, 8'h11, 8'h22);
        // aliased channel number reaches the same tracker
        send_command(mmenc_pkg::MODE_SILENCE, 8'hF2, 8'hFF, 8'hFF);
        send_command(mmenc_pkg::MODE_SILENCE, 8'h02, 8'h00, 8'h00);
        send_command(mmenc_pkg::MODE_TRACKED, 8'h02, 8'h91, 8'h7F);
        send_command(mmenc_pkg::MODE_SILENCE, 8'h02, 8'h00, 8'h00);
    endtask

    // mostly chord-like sequences ending in silence, mixed with random commands
    task automatic test_random_traffic();
        int         counted;
        int         k;
        logic [3:0] ch;
        logic [3:0] mode;
        counted = 0;
        while (counted < RANDOM_CMDS)
        begin
            calm <= (counted >= 120 && counted < 180);
            if ($urandom_range(99) < 65)
            begin
                ch = 4'($urandom_range(15));
                k = $urandom_range(8, 1);
                for (int i = 0; i < k; i++)
                begin
                    send_command(mmenc_pkg::MODE_TRACKED, {4'($urandom_range(15)), ch},
                                 8'($urandom), 8'($urandom));
                    counted++;
                    if ($urandom_range(3) == 0)
                    begin
                        send_command(4'($urandom_range(mmenc_pkg::MODE_REPORT)),
                                     8'($urandom), 8'($urandom), 8'($urandom));
                        counted++;
                    end
                end
                // most sequences get released, some are left to pile up
                if ($urandom_range(4) != 0)
                begin
                    send_command(mmenc_pkg::MODE_SILENCE, {4'($urandom_range(15)), ch},
                                 8'($urandom), 8'($urandom));
                    counted++;
                end
            end
            else
            begin
                mode = 4'($urandom_range(15));
                send_command(mode, 8'($urandom), 8'($urandom), 8'($urandom));
                if (mode <= mmenc_pkg::MODE_REPORT)
                    counted++;
            end
        end
        calm <= 1'b0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mmenc_pkg::MODE_CC;
        calm          <= 1'b0;
        mismatches    = 0;
        commands_sent = 0;
        beats_checked = 0;
        releases_seen = 0;
        byte_tally = '0;
        msg_tally  = '0;
        on_tally   = '0;
        off_tally  = '0;
        ctrl_tally = '0;
        for (int c = 0; c < mmenc_pkg::NUM_CHANNELS; c++)
            note_fill[c] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_message_types();
        test_note_tracking();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        // room for any stray beat to show up
        repeat (40) @(posedge clk);

        $display("covered %0d commands and %0d output beats, %0d of them note releases",
                 commands_sent, beats_checked, releases_seen);
        if (mismatches == 0)
            $display("midi_message_encoder_with_note_tracker_tb: done, clean");
        else
            $display("midi_message_encoder_with_note_tracker_tb: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d beats still expected", pending_beats.size());
        $display("midi_message_encoder_with_note_tracker_tb: done, errors");
        $finish;
    end

endmodule
